// ----- design/pbc_pkg.sv -----
// shared types, constants and fixed point helpers for the pixel blend compositor
package pbc_pkg;

    localparam int DATA_W        = 16;
    localparam int DW            = 24;
    localparam int PW            = 40;
    localparam int FRAC_BITS_DEF = 12;
    localparam int UNIT_STAGES   = 8;
    localparam int DIV_W         = 32;
    localparam int ROOT_W        = 16;
    localparam int DIV_STEPS     = DIV_W / UNIT_STAGES;
    localparam int SQRT_STEPS    = ROOT_W / UNIT_STAGES;
    localparam int PIPE_STAGES   = UNIT_STAGES + 5;
    localparam int CFG_ADDR_W    = 4;

    localparam logic [4:0] MODE_OVER     = 5'd0;
    localparam logic [4:0] MODE_COPY     = 5'd1;
    localparam logic [4:0] MODE_UNDER    = 5'd2;
    localparam logic [4:0] MODE_ATOP     = 5'd3;
    localparam logic [4:0] MODE_IN       = 5'd4;
    localparam logic [4:0] MODE_OUT      = 5'd5;
    localparam logic [4:0] MODE_SCREEN   = 5'd6;
    localparam logic [4:0] MODE_ADD      = 5'd7;
    localparam logic [4:0] MODE_SUBTRACT = 5'd8;
    localparam logic [4:0] MODE_MULTIPLY = 5'd9;
    localparam logic [4:0] MODE_MAX      = 5'd10;
    localparam logic [4:0] MODE_MIN      = 5'd11;
    localparam logic [4:0] MODE_AVERAGE  = 5'd12;
    localparam logic [4:0] MODE_DIFF     = 5'd13;
    localparam logic [4:0] MODE_OVERLAY  = 5'd14;
    localparam logic [4:0] MODE_SOFT     = 5'd15;
    localparam logic [4:0] MODE_DIVIDE   = 5'd16;
    localparam logic [4:0] MODE_XOR      = 5'd17;
    localparam logic [4:0] MODE_NONE     = 5'd18;

    localparam logic [CFG_ADDR_W-1:0] REG_COLOR_MODE  = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ALPHA_MODE  = 4'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MASK_GAIN   = 4'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_FRONT_GAIN  = 4'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_BACK_GAIN   = 4'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_MASK_PRES   = 4'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_FRONT_ALPHA = 4'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_BACK_ALPHA  = 4'd7;

    localparam logic signed [PW-1:0] SAT_MAX = PW'(32767);
    localparam logic signed [PW-1:0] SAT_MIN = PW'(-32768);

    typedef struct packed {
        logic [4:0]               color_mode;
        logic [4:0]               alpha_mode;
        logic signed [DATA_W-1:0] mask_gain;
        logic signed [DATA_W-1:0] front_gain;
        logic signed [DATA_W-1:0] back_gain;
        logic                     mask_present;
        logic                     front_has_alpha;
        logic                     back_has_alpha;
    } cfg_t;

    // first field sits in the highest bits
    typedef struct packed {
        logic signed [DATA_W-1:0] mask_level;
        logic signed [DATA_W-1:0] back_alpha;
        logic signed [DATA_W-1:0] back_blue;
        logic signed [DATA_W-1:0] back_green;
        logic signed [DATA_W-1:0] back_red;
        logic signed [DATA_W-1:0] front_alpha;
        logic signed [DATA_W-1:0] front_blue;
        logic signed [DATA_W-1:0] front_green;
        logic signed [DATA_W-1:0] front_red;
    } pix_t;

    typedef struct packed {
        logic signed [DW-1:0] f;
        logic signed [DW-1:0] b;
        logic signed [DW-1:0] r;
    } chan_t;

    typedef struct packed {
        chan_t [2:0]              ch;
        logic signed [DW-1:0]     a1;
        logic signed [DW-1:0]     a2;
        logic signed [DATA_W-1:0] op;
    } front_t;

    // product shifted down with round half up
    function automatic logic signed [PW-1:0] mulq(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b,
                                                  input int frac);
        logic signed [2*DW-1:0] p;
        p = a * b;
        p = p + ((2*DW)'(1) <<< (frac - 1));
        return PW'(p >>> frac);
    endfunction

    function automatic logic signed [DATA_W-1:0] sat16(input logic signed [PW-1:0] x);
        if (x > SAT_MAX)
            return DATA_W'(SAT_MAX);
        else if (x < SAT_MIN)
            return DATA_W'(SAT_MIN);
        else
            return DATA_W'(x);
    endfunction

    function automatic logic signed [DW-1:0] clamp01(input logic signed [PW-1:0] x,
                                                     input logic signed [DW-1:0] one);
        if (x < 0)
            return '0;
        else if (x > PW'(one))
            return one;
        else
            return DW'(x);
    endfunction

endpackage

// ----- design/pixel_blend_compositor_top.sv -----
// top level of the pixel blend compositor: config registers, stream ports, valid pipeline
//
// Per-pixel compositor. Each input item carries a foreground RGBA pixel, a
// background RGBA pixel and a mask level; each output item carries the
// composited RGBA pixel, all signed fixed point with FRAC_BITS fraction bits.
// The datapath is fully pipelined: one item is accepted every cycle unless
// the output is held. The pipeline is PIPE_STAGES register stages deep (13
// by default). The depth is set by the divider and square root units, each 8
// register stages deep (4 quotient bits and 2 root bits per stage), plus
// input, scaling, product, mode value and mix stages around them. A held
// output stalls the whole pipeline in place; no item is lost or repeated.
// Configuration is written through the cfg port, always ready, and should
// only change while no items are in flight. Writes to an index above 7 are
// ignored. There is no clearing pass and no start-up delay after reset.
module pixel_blend_compositor_top #(
    parameter int FRAC_BITS = pbc_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // slave side
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // front_red, front_green, front_blue, front_alpha, back_red, back_green,
    // back_blue, back_alpha, mask_level, 16 bits each from the lowest bit up
    input  logic [143:0]                      s_axis_tdata,
    // master side
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // out_red, out_green, out_blue, out_alpha, 16 bits each from the lowest bit up
    output logic [63:0]                       m_axis_tdata,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pbc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [15:0]                       cfg_data
);

    localparam int LAT = pbc_pkg::PIPE_STAGES;

    pbc_pkg::cfg_t   cfg_reg;
    pbc_pkg::pix_t   pix_reg;
    pbc_pkg::front_t front;
    logic [LAT-1:0]  valid_reg;
    logic            pipe_en;
    logic [4:0]      alpha_code;
    logic signed [pbc_pkg::DATA_W-1:0] res [4];
    pbc_pkg::chan_t  alpha_ch;

    // whole pipeline advances unless the output item is held
    assign pipe_en       = !valid_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = pipe_en;
    assign m_axis_tvalid = valid_reg[LAT-1];
    assign cfg_ready     = 1'b1;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.color_mode      <= pbc_pkg::MODE_OVER;
            cfg_reg.alpha_mode      <= pbc_pkg::MODE_OVER;
            cfg_reg.mask_gain       <= 16'sd4096;
            cfg_reg.front_gain      <= 16'sd4096;
            cfg_reg.back_gain       <= 16'sd4096;
            cfg_reg.mask_present    <= 1'b0;
            cfg_reg.front_has_alpha <= 1'b0;
            cfg_reg.back_has_alpha  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_addr)
                pbc_pkg::REG_COLOR_MODE:  cfg_reg.color_mode      <= cfg_data[4:0];
                pbc_pkg::REG_ALPHA_MODE:  cfg_reg.alpha_mode      <= cfg_data[4:0];
                pbc_pkg::REG_MASK_GAIN:   cfg_reg.mask_gain       <= cfg_data;
                pbc_pkg::REG_FRONT_GAIN:  cfg_reg.front_gain      <= cfg_data;
                pbc_pkg::REG_BACK_GAIN:   cfg_reg.back_gain       <= cfg_data;
                pbc_pkg::REG_MASK_PRES:   cfg_reg.mask_present    <= cfg_data[0];
                pbc_pkg::REG_FRONT_ALPHA: cfg_reg.front_has_alpha <= cfg_data[0];
                pbc_pkg::REG_BACK_ALPHA:  cfg_reg.back_has_alpha  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // valid bits travel alongside the payload stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (pipe_en)
            valid_reg <= {valid_reg[LAT-2:0], s_axis_tvalid};
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (pipe_en)
            pix_reg <= pbc_pkg::pix_t'(s_axis_tdata);
    end

    pbc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk   (clk),
        .en    (pipe_en),
        .cfg   (cfg_reg),
        .pix   (pix_reg),
        .front (front)
    );

    // colour lanes
    for (genvar i = 0; i < 3; i++)
    begin : g_color
        pbc_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .clk     (clk),
            .en      (pipe_en),
            .code    (cfg_reg.color_mode),
            .ch      (front.ch[i]),
            .a_front (front.a1),
            .a_back  (front.a2),
            .op      (front.op),
            .res     (res[i])
        );
    end

    // alpha lane: overlay, soft light and divide do not apply to alpha
    always_comb
    begin
        case (cfg_reg.alpha_mode)
            pbc_pkg::MODE_OVERLAY,
            pbc_pkg::MODE_SOFT,
            pbc_pkg::MODE_DIVIDE: alpha_code = pbc_pkg::MODE_NONE;
            default:              alpha_code = cfg_reg.alpha_mode;
        endcase
        alpha_ch.f = front.a1;
        alpha_ch.b = front.a2;
        alpha_ch.r = front.a2;
    end

    pbc_lane #(.FRAC_BITS(FRAC_BITS)) u_alpha (
        .clk     (clk),
        .en      (pipe_en),
        .code    (alpha_code),
        .ch      (alpha_ch),
        .a_front (front.a1),
        .a_back  (front.a2),
        .op      (front.op),
        .res     (res[3])
    );

    // alpha result is zero when neither image carries alpha
    assign m_axis_tdata = {
        (cfg_reg.front_has_alpha || cfg_reg.back_has_alpha) ? res[3] : 16'sd0,
        res[2], res[1], res[0]};

    // a stalled pipeline keeps every valid bit in place
    assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(valid_reg))
    else $error("valid pipeline moved during a stall");

    // an empty pipeline cannot produce an output item in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg == '0) |=> !m_axis_tvalid)
    else $error("output item appeared from an empty pipeline");

    // taking the last item drains the output when nothing follows it
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !valid_reg[LAT-2]) |=> !m_axis_tvalid)
    else $error("output item repeated after it was taken");

endmodule

// ----- design/pbc_front.sv -----
// input scaling stage: gains, alpha and mask clamps
module pbc_front #(
    parameter int FRAC_BITS = pbc_pkg::FRAC_BITS_DEF
) (
    input  logic            clk,
    input  logic            en,
    input  pbc_pkg::cfg_t   cfg,
    input  pbc_pkg::pix_t   pix,
    output pbc_pkg::front_t front
);

    localparam logic signed [pbc_pkg::DW-1:0] ONE = pbc_pkg::DW'(1) <<< FRAC_BITS;

    pbc_pkg::front_t front_reg;
    pbc_pkg::front_t front_next;

    logic signed [pbc_pkg::DW-1:0]     m;
    logic signed [pbc_pkg::DW-1:0]     fa;
    logic signed [pbc_pkg::DW-1:0]     ba;
    logic signed [pbc_pkg::DATA_W-1:0] fc [3];
    logic signed [pbc_pkg::DATA_W-1:0] bc [3];

    always_comb
    begin
        fc[0] = pix.front_red;
        fc[1] = pix.front_green;
        fc[2] = pix.front_blue;
        bc[0] = pix.back_red;
        bc[1] = pix.back_green;
        bc[2] = pix.back_blue;
        m  = cfg.mask_present ? pbc_pkg::clamp01(pbc_pkg::PW'(pix.mask_level), ONE) : ONE;
        fa = cfg.front_has_alpha ? pbc_pkg::DW'(pix.front_alpha) : ONE;
        ba = cfg.back_has_alpha ? pbc_pkg::DW'(pix.back_alpha) : ONE;
        front_next.op = pbc_pkg::sat16(pbc_pkg::mulq(m, pbc_pkg::DW'(cfg.mask_gain), FRAC_BITS));
        front_next.a1 = pbc_pkg::clamp01(
            pbc_pkg::mulq(fa, pbc_pkg::DW'(cfg.front_gain), FRAC_BITS), ONE);
        front_next.a2 = pbc_pkg::clamp01(
            pbc_pkg::mulq(ba, pbc_pkg::DW'(cfg.back_gain), FRAC_BITS), ONE);
        for (int i = 0; i < 3; i++)
        begin
            front_next.ch[i].f = pbc_pkg::DW'(pbc_pkg::sat16(pbc_pkg::mulq(
                pbc_pkg::DW'(fc[i]), pbc_pkg::DW'(cfg.front_gain), FRAC_BITS)));
            front_next.ch[i].b = pbc_pkg::DW'(pbc_pkg::sat16(pbc_pkg::mulq(
                pbc_pkg::DW'(bc[i]), pbc_pkg::DW'(cfg.back_gain), FRAC_BITS)));
            front_next.ch[i].r = pbc_pkg::DW'(bc[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            front_reg <= front_next;
    end

    assign front = front_reg;

endmodule

// ----- design/pbc_div.sv -----
// pipelined restoring divider, saturated signed quotient
module pbc_div #(
    parameter int FRAC_BITS = pbc_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic signed [pbc_pkg::DATA_W-1:0] num,
    input  logic signed [pbc_pkg::DATA_W-1:0] den,
    output logic signed [pbc_pkg::DATA_W-1:0] quo
);

    localparam int DV = pbc_pkg::DIV_W;
    localparam logic signed [pbc_pkg::PW-1:0] ONE = pbc_pkg::PW'(1) <<< FRAC_BITS;

    typedef struct packed {
        logic [DV-1:0] num;
        logic [15:0]   rem;
        logic [DV-1:0] quo;
        logic [15:0]   den;
        logic          neg;
        logic          zero;
    } div_t;

    div_t st_reg  [pbc_pkg::UNIT_STAGES];
    div_t st_next [pbc_pkg::UNIT_STAGES];
    div_t init;
    div_t last;

    function automatic div_t div_steps(input div_t s);
        div_t        o;
        logic [16:0] t;
        o = s;
        for (int i = 0; i < pbc_pkg::DIV_STEPS; i++)
        begin
            t = {o.rem, o.num[DV-1]};
            o.num = {o.num[DV-2:0], 1'b0};
            if (t >= {1'b0, o.den})
            begin
                o.rem = 16'(t - {1'b0, o.den});
                o.quo = {o.quo[DV-2:0], 1'b1};
            end
            else
            begin
                o.rem = t[15:0];
                o.quo = {o.quo[DV-2:0], 1'b0};
            end
        end
        return o;
    endfunction

    always_comb
    begin
        // magnitude taken as unsigned so that the most negative value stays 32768
        init.num  = DV'($unsigned(num[15] ? 16'(-num) : 16'(num))) << FRAC_BITS;
        init.den  = den[15] ? 16'(-den) : 16'(den);
        init.rem  = '0;
        init.quo  = '0;
        init.neg  = num[15] ^ den[15];
        init.zero = (den == '0);
        st_next[0] = div_steps(init);
        for (int k = 1; k < pbc_pkg::UNIT_STAGES; k++)
            st_next[k] = div_steps(st_reg[k-1]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < pbc_pkg::UNIT_STAGES; k++)
                st_reg[k] <= st_next[k];
        end
    end

    always_comb
    begin
        last = st_reg[pbc_pkg::UNIT_STAGES-1];
        if (last.zero)
            quo = pbc_pkg::sat16(ONE);
        else if (last.neg)
            quo = (last.quo > DV'(32768)) ? 16'sh8000 : 16'(-last.quo);
        else
            quo = (last.quo > DV'(32767)) ? 16'sh7fff : 16'(last.quo);
    end

endmodule

// ----- design/pbc_sqrt.sv -----
// pipelined digit by digit square root of the fixed point value
module pbc_sqrt #(
    parameter int FRAC_BITS = pbc_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [pbc_pkg::DATA_W-1:0] val,
    output logic [pbc_pkg::ROOT_W-1:0]        root
);

    localparam int DV = pbc_pkg::DIV_W;
    localparam int RW = pbc_pkg::ROOT_W;

    typedef struct packed {
        logic [DV-1:0]   num;
        logic [RW+1:0]   rem;
        logic [RW-1:0]   root;
    } sqrt_t;

    sqrt_t st_reg  [pbc_pkg::UNIT_STAGES];
    sqrt_t st_next [pbc_pkg::UNIT_STAGES];
    sqrt_t init;

    function automatic sqrt_t sqrt_steps(input sqrt_t s);
        sqrt_t         o;
        logic [RW+3:0] t;
        logic [RW+3:0] trial;
        o = s;
        for (int i = 0; i < pbc_pkg::SQRT_STEPS; i++)
        begin
            t     = {o.rem, o.num[DV-1:DV-2]};
            trial = {2'b00, o.root, 2'b01};
            o.num = {o.num[DV-3:0], 2'b00};
            if (t >= trial)
            begin
                o.rem  = (RW+2)'(t - trial);
                o.root = {o.root[RW-2:0], 1'b1};
            end
            else
            begin
                o.rem  = t[RW+1:0];
                o.root = {o.root[RW-2:0], 1'b0};
            end
        end
        return o;
    endfunction

    always_comb
    begin
        // negative input counts as zero
        init.num  = (val > 0) ? (DV'(val[14:0]) << FRAC_BITS) : '0;
        init.rem  = '0;
        init.root = '0;
        st_next[0] = sqrt_steps(init);
        for (int k = 1; k < pbc_pkg::UNIT_STAGES; k++)
            st_next[k] = sqrt_steps(st_reg[k-1]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < pbc_pkg::UNIT_STAGES; k++)
                st_reg[k] <= st_next[k];
        end
    end

    assign root = st_reg[pbc_pkg::UNIT_STAGES-1].root;

endmodule

// ----- design/pbc_lane.sv -----
// one channel of the blend datapath: products, mode value and background mix
module pbc_lane #(
    parameter int FRAC_BITS = pbc_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic [4:0]                        code,
    input  pbc_pkg::chan_t                    ch,
    input  logic signed [pbc_pkg::DW-1:0]     a_front,
    input  logic signed [pbc_pkg::DW-1:0]     a_back,
    input  logic signed [pbc_pkg::DATA_W-1:0] op,
    output logic signed [pbc_pkg::DATA_W-1:0] res
);

    localparam int DW = pbc_pkg::DW;
    localparam int PW = pbc_pkg::PW;
    localparam int NS = pbc_pkg::UNIT_STAGES;
    localparam logic signed [DW-1:0] ONE  = DW'(1) <<< FRAC_BITS;
    localparam logic signed [DW-1:0] HALF = DW'(1) <<< (FRAC_BITS - 1);

    typedef struct packed {
        logic signed [DW-1:0]             f;
        logic signed [DW-1:0]             b;
        logic signed [DW-1:0]             r;
        logic signed [pbc_pkg::DATA_W-1:0] op;
        logic signed [PW-1:0]             p1;
        logic signed [PW-1:0]             p2;
    } side_t;

    typedef struct packed {
        side_t                             s;
        logic signed [PW-1:0]              p3;
        logic signed [pbc_pkg::DATA_W-1:0] divq;
    } prod_t;

    typedef struct packed {
        logic signed [pbc_pkg::DATA_W-1:0] v;
        logic                              ok;
        logic signed [DW-1:0]              r;
        logic signed [pbc_pkg::DATA_W-1:0] op;
    } val_t;

    side_t side_reg [NS];
    side_t side_next;
    prod_t prod_reg;
    prod_t prod_next;
    val_t  val_reg;
    val_t  val_next;
    logic signed [pbc_pkg::DATA_W-1:0] res_reg;
    logic signed [pbc_pkg::DATA_W-1:0] res_next;

    logic signed [DW-1:0] onef, oneb, na1, na2, ma, mb, na, nb, x, y;
    logic signed [PW-1:0] fp, bp, sum, v;
    logic signed [pbc_pkg::DATA_W-1:0] divq;
    logic [pbc_pkg::ROOT_W-1:0]        root;
    side_t ls;
    side_t ps;

    pbc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk (clk),
        .en  (en),
        .num (ch.b[pbc_pkg::DATA_W-1:0]),
        .den (ch.f[pbc_pkg::DATA_W-1:0]),
        .quo (divq)
    );

    pbc_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
        .clk  (clk),
        .en   (en),
        .val  (ch.b[pbc_pkg::DATA_W-1:0]),
        .root (root)
    );

    // operand selection for the first products
    always_comb
    begin
        onef = ONE - ch.f;
        oneb = ONE - ch.b;
        na1  = ONE - a_front;
        na2  = ONE - a_back;
        ma = ch.f;
        mb = ch.b;
        na = ch.b;
        nb = ch.b;
        case (code)
            pbc_pkg::MODE_OVER:
            begin
                ma = ch.b;
                mb = na1;
            end
            pbc_pkg::MODE_UNDER: mb = na2;
            pbc_pkg::MODE_ATOP:
            begin
                mb = a_back;
                nb = na1;
            end
            pbc_pkg::MODE_IN:  mb = a_back;
            pbc_pkg::MODE_OUT: mb = na2;
            pbc_pkg::MODE_SCREEN:
            begin
                ma = oneb;
                mb = onef;
            end
            pbc_pkg::MODE_XOR:
            begin
                mb = na2;
                nb = na1;
            end
            pbc_pkg::MODE_OVERLAY:
            begin
                if (ch.r >= HALF)
                begin
                    ma = onef;
                    mb = oneb;
                end
            end
            pbc_pkg::MODE_SOFT:
            begin
                if (ch.f >= HALF)
                begin
                    ma = ch.b;
                    mb = onef;
                end
            end
            default: ;
        endcase
        side_next.f  = ch.f;
        side_next.b  = ch.b;
        side_next.r  = ch.r;
        side_next.op = op;
        side_next.p1 = pbc_pkg::mulq(ma, mb, FRAC_BITS);
        side_next.p2 = pbc_pkg::mulq(na, nb, FRAC_BITS);
    end

    // soft light second product, aligned with the divider and root outputs
    always_comb
    begin
        ls = side_reg[NS-1];
        if (ls.f < HALF)
        begin
            x = DW'(ls.p2);
            y = ONE - (ls.f <<< 1);
        end
        else
        begin
            x = DW'(root);
            y = (ls.f <<< 1) - ONE;
        end
        prod_next.s    = ls;
        prod_next.p3   = pbc_pkg::mulq(x, y, FRAC_BITS);
        prod_next.divq = divq;
    end

    // mode value
    always_comb
    begin
        ps  = prod_reg.s;
        fp  = PW'(ps.f);
        bp  = PW'(ps.b);
        sum = fp + bp + PW'(1);
        val_next.ok = 1'b1;
        case (code)
            pbc_pkg::MODE_OVER:     v = fp + ps.p1;
            pbc_pkg::MODE_COPY:     v = fp;
            pbc_pkg::MODE_UNDER:    v = bp + ps.p1;
            pbc_pkg::MODE_ATOP:     v = ps.p1 + ps.p2;
            pbc_pkg::MODE_IN:       v = ps.p1;
            pbc_pkg::MODE_OUT:      v = ps.p1;
            pbc_pkg::MODE_SCREEN:   v = PW'(ONE) - ps.p1;
            pbc_pkg::MODE_ADD:      v = fp + bp;
            pbc_pkg::MODE_SUBTRACT: v = bp - fp;
            pbc_pkg::MODE_MULTIPLY: v = ps.p1;
            pbc_pkg::MODE_MAX:      v = (fp > bp) ? fp : bp;
            pbc_pkg::MODE_MIN:      v = (fp < bp) ? fp : bp;
            pbc_pkg::MODE_AVERAGE:  v = sum >>> 1;
            pbc_pkg::MODE_DIFF:     v = (fp > bp) ? fp - bp : bp - fp;
            pbc_pkg::MODE_XOR:      v = ps.p1 + ps.p2;
            pbc_pkg::MODE_OVERLAY:
                v = (ps.r < HALF) ? (ps.p1 <<< 1) : PW'(ONE) - (ps.p1 <<< 1);
            pbc_pkg::MODE_SOFT:     v = (ps.p1 <<< 1) + prod_reg.p3;
            pbc_pkg::MODE_DIVIDE:   v = PW'(prod_reg.divq);
            default:
            begin
                v = '0;
                val_next.ok = 1'b0;
            end
        endcase
        val_next.v  = pbc_pkg::sat16(v);
        val_next.r  = ps.r;
        val_next.op = ps.op;
    end

    // mix with the background value r (the unscaled background in the colour lanes)
    always_comb
    begin
        if (val_reg.ok)
            res_next = pbc_pkg::sat16(
                pbc_pkg::mulq(DW'(val_reg.v), DW'(val_reg.op), FRAC_BITS) +
                pbc_pkg::mulq(val_reg.r, ONE - DW'(val_reg.op), FRAC_BITS));
        else
            res_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_next;
            for (int k = 1; k < NS; k++)
                side_reg[k] <= side_reg[k-1];
            prod_reg <= prod_next;
            val_reg  <= val_next;
            res_reg  <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ----- sim/pixel_blend_compositor_top_tb.sv -----
// testbench for the pixel blend compositor: predictor, stream driver, monitor and checks
`timescale 1ns / 1ps

module pixel_blend_compositor_top_tb;

    localparam int  FRAC      = 12;
    localparam longint ONE_Q  = 64'sd1 << FRAC;
    localparam longint HALF_Q = 64'sd1 << (FRAC - 1);
    localparam int  LATENCY   = pbc_pkg::PIPE_STAGES;
    localparam int  WATCHDOG  = 20000;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata;   // front r,g,b,a, back r,g,b,a, mask level, 16 bits each
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;   // out red, green, blue, alpha, 16 bits each
    logic         cfg_valid;
    logic         cfg_ready;
    logic [pbc_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [15:0]  cfg_data;

    pixel_blend_compositor_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // shadow copy of the configuration registers
    logic [4:0]   sh_color;
    logic [4:0]   sh_alpha;
    longint       sh_mask_gain;
    longint       sh_front_gain;
    longint       sh_back_gain;
    bit           sh_mask_pres;
    bit           sh_front_alpha;
    bit           sh_back_alpha;

    logic [143:0] pixel_queue[$];     // items waiting for the driver
    logic [63:0]  expected_pixels[$]; // composited pixels still to arrive
    int           errors;
    int           pixels_in;
    int           pixels_out;
    int           idle_pct_in;
    int           idle_pct_out;
    int           hold_out;           // cycles the receiver holds off outright
    int           quiet_cycles;

    // ---------------- fixed point helpers ----------------
    function automatic longint sx16(logic [15:0] x);
        return longint'(signed'(x));
    endfunction

    function automatic longint sat_q(longint x);
        return x > 32767 ? 32767 : (x < -32768 ? -32768 : x);
    endfunction

    function automatic longint unit_clamp(longint x);
        return x < 0 ? 0 : (x > ONE_Q ? ONE_Q : x);
    endfunction

    // product with round half up, floor shift of the biased value
    function automatic longint qmul(longint a, longint b);
        longint q;
        q = a * b + HALF_Q;
        return q >>> FRAC;
    endfunction

    function automatic longint q_root(longint b);
        longint r;
        longint n;
        if (b <= 0)
            return 0;
        n = b << FRAC;
        r = 0;
        while ((r + 1) * (r + 1) <= n)
            r = r + 1;
        return r;
    endfunction

    function automatic longint q_divide(longint b, longint f);
        longint nb;
        longint nf;
        longint q;
        if (f == 0)
            return ONE_Q;
        nb = (b < 0 ? -b : b) << FRAC;
        nf = f < 0 ? -f : f;
        q = nb / nf;
        return ((b < 0) != (f < 0)) ? -q : q;
    endfunction

    // porter-duff and arithmetic modes common to colour and alpha
    function automatic bit shared_mode(logic [4:0] code, longint f, longint b,
                                       longint a1, longint a2, output longint v);
        longint s;
        v = 0;
        case (code)
            pbc_pkg::MODE_OVER:     v = f + qmul(b, ONE_Q - a1);
            pbc_pkg::MODE_COPY:     v = f;
            pbc_pkg::MODE_UNDER:    v = b + qmul(f, ONE_Q - a2);
            pbc_pkg::MODE_ATOP:     v = qmul(f, a2) + qmul(b, ONE_Q - a1);
            pbc_pkg::MODE_IN:       v = qmul(f, a2);
            pbc_pkg::MODE_OUT:      v = qmul(f, ONE_Q - a2);
            pbc_pkg::MODE_SCREEN:   v = ONE_Q - qmul(ONE_Q - b, ONE_Q - f);
            pbc_pkg::MODE_ADD:      v = f + b;
            pbc_pkg::MODE_SUBTRACT: v = b - f;
            pbc_pkg::MODE_MULTIPLY: v = qmul(f, b);
            pbc_pkg::MODE_MAX:      v = f > b ? f : b;
            pbc_pkg::MODE_MIN:      v = f < b ? f : b;
            pbc_pkg::MODE_AVERAGE:
            begin
                s = f + b + 1;
                v = s >= 0 ? (s >>> 1) : -((-s + 1) >>> 1);
            end
            pbc_pkg::MODE_DIFF:     v = f > b ? f - b : b - f;
            pbc_pkg::MODE_XOR:      v = qmul(f, ONE_Q - a2) + qmul(b, ONE_Q - a1);
            default:                return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic logic [63:0] composite_pixel(logic [143:0] px);
        logic [63:0] res;
        longint m, op, fa, ba, a1, a2, f, r, b, v, o;
        bit ok;
        res = '0;
        m  = sh_mask_pres ? unit_clamp(sx16(px[128 +: 16])) : ONE_Q;
        op = sat_q(qmul(m, sh_mask_gain));
        fa = sh_front_alpha ? sx16(px[48 +: 16]) : ONE_Q;
        ba = sh_back_alpha ? sx16(px[112 +: 16]) : ONE_Q;
        a1 = unit_clamp(qmul(fa, sh_front_gain));
        a2 = unit_clamp(qmul(ba, sh_back_gain));
        for (int c = 0; c < 3; c++)
        begin
            f  = sat_q(qmul(sx16(px[16*c +: 16]), sh_front_gain));
            r  = sx16(px[64 + 16*c +: 16]);
            b  = sat_q(qmul(r, sh_back_gain));
            ok = 1'b1;
            v  = 0;
            if (sh_color == pbc_pkg::MODE_OVERLAY)
                v = r < HALF_Q ? 2 * qmul(f, b) : ONE_Q - 2 * qmul(ONE_Q - f, ONE_Q - b);
            else if (sh_color == pbc_pkg::MODE_SOFT)
            begin
                if (f < HALF_Q)
                    v = 2 * qmul(f, b) + qmul(qmul(b, b), ONE_Q - 2 * f);
                else
                    v = 2 * qmul(b, ONE_Q - f) + qmul(q_root(b), 2 * f - ONE_Q);
            end
            else if (sh_color == pbc_pkg::MODE_DIVIDE)
                v = q_divide(b, f);
            else
                ok = shared_mode(sh_color, f, b, a1, a2, v);
            o = ok ? sat_q(qmul(sat_q(v), op) + qmul(r, ONE_Q - op)) : 0;
            res[16*c +: 16] = o[15:0];
        end
        if (sh_front_alpha || sh_back_alpha)
        begin
            o = 0;
            if (shared_mode(sh_alpha, a1, a2, a1, a2, v))
                o = sat_q(qmul(sat_q(v), op) + qmul(a2, ONE_Q - op));
            res[48 +: 16] = o[15:0];
        end
        return res;
    endfunction

    // ---------------- driver ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_pixels.push_back(composite_pixel(s_axis_tdata));
                pixels_in++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pixel_queue.size() > 0 && $urandom_range(99) >= idle_pct_in)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pixel_queue.pop_front();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge clk or negedge rst_n)
    begin
        logic [63:0] want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                pixels_out++;
                if (expected_pixels.size() == 0)
                begin
                    $error("unexpected item %h", m_axis_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (want[15:0] !== m_axis_tdata[15:0])
                    begin
                        $error("out_red exp %h got %h", want[15:0], m_axis_tdata[15:0]);
                        errors++;
                    end
                    if (want[31:16] !== m_axis_tdata[31:16])
                    begin
                        $error("out_green exp %h got %h", want[31:16], m_axis_tdata[31:16]);
                        errors++;
                    end
                    if (want[47:32] !== m_axis_tdata[47:32])
                    begin
                        $error("out_blue exp %h got %h", want[47:32], m_axis_tdata[47:32]);
                        errors++;
                    end
                    if (want[63:48] !== m_axis_tdata[63:48])
                    begin
                        $error("out_alpha exp %h got %h", want[63:48], m_axis_tdata[63:48]);
                        errors++;
                    end
                end
            end
            // long hold-off counted here, random stalls otherwise
            if (hold_out > 0)
            begin
                hold_out <= hold_out - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= idle_pct_out);
        end
    end

    // watchdog on cycles without any accepted item or config write
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n
            || cfg_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("watchdog expired, %0d items outstanding", expected_pixels.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    function automatic logic [15:0] pick_value();
        case ($urandom_range(7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h1000;
            3: return 16'h0000;
            4: return 16'(HALF_Q);
            5: return 16'($urandom_range(0, 4096));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [143:0] random_pixel();
        logic [143:0] px;
        for (int k = 0; k < 9; k++)
            px[16*k +: 16] = ($urandom_range(3) == 0) ? pick_value() : 16'($urandom_range(0, 4096));
        return px;
    endfunction

    task automatic write_reg(logic [pbc_pkg::CFG_ADDR_W-1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            pbc_pkg::REG_COLOR_MODE:  sh_color       = val[4:0];
            pbc_pkg::REG_ALPHA_MODE:  sh_alpha       = val[4:0];
            pbc_pkg::REG_MASK_GAIN:   sh_mask_gain   = sx16(val);
            pbc_pkg::REG_FRONT_GAIN:  sh_front_gain  = sx16(val);
            pbc_pkg::REG_BACK_GAIN:   sh_back_gain   = sx16(val);
            pbc_pkg::REG_MASK_PRES:   sh_mask_pres   = val[0];
            pbc_pkg::REG_FRONT_ALPHA: sh_front_alpha = val[0];
            pbc_pkg::REG_BACK_ALPHA:  sh_back_alpha  = val[0];
            default: ;
        endcase
    endtask

    // every item out and the pipe drained before touching registers
    task automatic drain();
        while (pixel_queue.size() > 0 || s_axis_tvalid || expected_pixels.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic random_config();
        logic [15:0] g[3];
        for (int k = 0; k < 3; k++)
            case ($urandom_range(5))
                0: g[k] = 16'h7FFF;
                1: g[k] = 16'h8000;
                2: g[k] = 16'h1000;
                3: g[k] = 16'h0000;
                default: g[k] = 16'($urandom_range(0, 6000));
            endcase
        write_reg(pbc_pkg::REG_COLOR_MODE, 16'($urandom_range(0, 19)));
        write_reg(pbc_pkg::REG_ALPHA_MODE, 16'($urandom_range(0, 19)));
        write_reg(pbc_pkg::REG_MASK_GAIN, g[0]);
        write_reg(pbc_pkg::REG_FRONT_GAIN, g[1]);
        write_reg(pbc_pkg::REG_BACK_GAIN, g[2]);
        write_reg(pbc_pkg::REG_MASK_PRES, 16'($urandom_range(1)));
        write_reg(pbc_pkg::REG_FRONT_ALPHA, 16'($urandom_range(1)));
        write_reg(pbc_pkg::REG_BACK_ALPHA, 16'($urandom_range(1)));
    endtask

    initial
    begin
        errors = 0; pixels_in = 0; pixels_out = 0;
        idle_pct_in = 0; idle_pct_out = 0; hold_out = 0; quiet_cycles = 0;
        sh_color = pbc_pkg::MODE_OVER; sh_alpha = pbc_pkg::MODE_OVER;
        sh_mask_gain = 4096; sh_front_gain = 4096; sh_back_gain = 4096;
        sh_mask_pres = 0; sh_front_alpha = 0; sh_back_alpha = 0;
        cfg_valid = 1'b0; cfg_addr = '0; cfg_data = '0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; m_axis_tready = 1'b0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: each colour mode with alpha on, on edge-case pixels
        write_reg(pbc_pkg::REG_MASK_PRES, 16'd1);
        write_reg(pbc_pkg::REG_FRONT_ALPHA, 16'd1);
        write_reg(pbc_pkg::REG_BACK_ALPHA, 16'd1);
        write_reg(pbc_pkg::REG_BACK_GAIN, 16'h1000);
        for (int mode = 0; mode < 19; mode++)
        begin
            write_reg(pbc_pkg::REG_COLOR_MODE, 16'(mode));
            write_reg(pbc_pkg::REG_ALPHA_MODE, 16'(mode));
            // zero front hits divide by zero; negative back hits the square root clamp
            pixel_queue.push_back({16'h0800, 16'h0800, 16'hF000, 16'h2000, 16'h0C00,
                                   16'h0800, 16'h0000, 16'h0000, 16'h0000});
            pixel_queue.push_back({16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0400,
                                   16'h7FFF, 16'h8000, 16'h0C00, 16'h7FFF});
            drain();
        end
        // alpha absent on both sides, then unsupported codes
        write_reg(pbc_pkg::REG_FRONT_ALPHA, 16'd0);
        write_reg(pbc_pkg::REG_BACK_ALPHA, 16'd0);
        write_reg(pbc_pkg::REG_COLOR_MODE, 16'd31);
        write_reg(pbc_pkg::REG_ALPHA_MODE, 16'd31);
        write_reg(4'd9, 16'h1234);   // out-of-range index, ignored
        pixel_queue.push_back({9{16'h0C00}});
        drain();

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 8; ph++)
        begin
            random_config();
            case (ph % 4)
                0: begin idle_pct_in = 0;  idle_pct_out = 0;  end
                1: begin idle_pct_in = 59; idle_pct_out = 0;  end
                2: begin idle_pct_in = 0;  idle_pct_out = 59; end
                default: begin idle_pct_in = 6; idle_pct_out = 6; end
            endcase
            if (ph == 2)
                hold_out = 200;   // back the pipe up while items keep coming
            for (int k = 0; k < 75; k++)
                pixel_queue.push_back(random_pixel());
            drain();   // sender pauses here until every result is back
        end

        repeat (LATENCY + 5) @(posedge clk);
        $display("covered %0d pixels in, %0d out, all modes and gain extremes",
                 pixels_in, pixels_out);
        if (errors == 0 && expected_pixels.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
